// ===== hw/rtl/cabs_pkg.sv =====
// ----------------------------------------------------------------------------
// cabs_pkg
// shared types and constants of the per-class box suppression block
// ----------------------------------------------------------------------------
package cabs_pkg;

	localparam int MAX_BOXES   = 64;
	localparam int CLASS_COUNT = 256;
	localparam int IDX_W       = $clog2(MAX_BOXES);
	localparam int CNT_W       = $clog2(MAX_BOXES + 1);
	localparam int THR_W       = 17;
	localparam int ADDR_W      = 2;
	localparam int DATA_W      = 32;

	localparam logic [THR_W-1:0]  THR_RESET   = THR_W'(29491);
	localparam logic [ADDR_W-1:0] REG_IOU_THR = ADDR_W'(0);

	typedef struct packed {
		logic signed [15:0] x1;
		logic signed [15:0] y1;
		logic signed [15:0] x2;
		logic signed [15:0] y2;
	} corners_t;

	typedef struct packed {
		logic signed [15:0] in_x1;
		logic signed [15:0] in_y1;
		logic signed [15:0] in_x2;
		logic signed [15:0] in_y2;
		logic [15:0]        in_score;
		logic [7:0]         in_class;
		logic               in_last_box;
	} box_in_t;

	typedef struct packed {
		logic signed [15:0] out_x1;
		logic signed [15:0] out_y1;
		logic signed [15:0] out_x2;
		logic signed [15:0] out_y2;
		logic [15:0]        out_score;
		logic [7:0]         out_class;
		logic               out_last_kept;
		logic               out_overflow;
	} box_out_t;

	typedef struct packed {
		corners_t    corners;
		logic [15:0] score;
		logic [7:0]  cls;
	} entry_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} cabs_tag_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_FIND,
		ST_SUPP,
		ST_EMIT
	} cabs_state_t;

endpackage

// ===== hw/rtl/cabs_box_mem.sv =====
// ----------------------------------------------------------------------------
// cabs_box_mem
// box store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module cabs_box_mem (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [cabs_pkg::IDX_W-1:0] wr_addr,
	input  cabs_pkg::entry_t         wr_data,
	input  logic                     rd_en,
	input  logic [cabs_pkg::IDX_W-1:0] rd_addr,
	output cabs_pkg::entry_t         rd_data
);
	import cabs_pkg::*;

	entry_t mem [MAX_BOXES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/cabs_iou.sv =====
// ----------------------------------------------------------------------------
// cabs_iou
// pipelined overlap test: intersection * 65536 > threshold * union
// ----------------------------------------------------------------------------
module cabs_iou (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cabs_pkg::cabs_tag_t        req,
	input  cabs_pkg::corners_t         a,
	input  cabs_pkg::corners_t         b,
	input  logic [cabs_pkg::THR_W-1:0] thr,
	output cabs_pkg::cabs_tag_t        rsp,
	output logic                       hit,
	output logic                       busy
);
	import cabs_pkg::*;

	function automatic logic [15:0] span(input logic signed [15:0] lo,
			input logic signed [15:0] hi);
		logic signed [16:0] diff;
		diff = 17'(hi) - 17'(lo);
		return (hi > lo) ? diff[15:0] : 16'd0;
	endfunction

	cabs_tag_t tag_s1, tag_s2, tag_s3, tag_s4;

	logic signed [15:0] ix1, iy1, ix2, iy2;
	logic [15:0] iw_s1, ih_s1, aw_s1, ah_s1, bw_s1, bh_s1;
	logic [31:0] inter_s2, area_a_s2, area_b_s2;
	logic [32:0] uni_s3;
	logic [31:0] inter_s3;
	logic [49:0] rhs_s4;
	logic [47:0] lhs_s4;
	logic        pos_s4;

	always_comb begin
		ix1 = (a.x1 > b.x1) ? a.x1 : b.x1;
		iy1 = (a.y1 > b.y1) ? a.y1 : b.y1;
		ix2 = (a.x2 < b.x2) ? a.x2 : b.x2;
		iy2 = (a.y2 < b.y2) ? a.y2 : b.y2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= req;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		iw_s1     <= span(ix1, ix2);
		ih_s1     <= span(iy1, iy2);
		aw_s1     <= span(a.x1, a.x2);
		ah_s1     <= span(a.y1, a.y2);
		bw_s1     <= span(b.x1, b.x2);
		bh_s1     <= span(b.y1, b.y2);
		inter_s2  <= iw_s1 * ih_s1;
		area_a_s2 <= aw_s1 * ah_s1;
		area_b_s2 <= bw_s1 * bh_s1;
		uni_s3    <= 33'(area_a_s2) + 33'(area_b_s2) - 33'(inter_s2);
		inter_s3  <= inter_s2;
		rhs_s4    <= 50'(thr) * 50'(uni_s3);
		lhs_s4    <= {inter_s3, 16'd0};
		pos_s4    <= (inter_s3 != 32'd0);
	end

	// union is positive whenever the intersection is
	assign hit  = pos_s4 && (50'(lhs_s4) > rhs_s4);
	assign rsp  = tag_s4;
	assign busy = tag_s1.vld | tag_s2.vld | tag_s3.vld | tag_s4.vld;

endmodule

// ===== hw/rtl/class_aware_box_suppression.sv =====
// ----------------------------------------------------------------------------
// class_aware_box_suppression
// greedy per-class non-maximum suppression over one set of boxes
// ----------------------------------------------------------------------------
// Boxes come in on the box channel, one beat each, and are written to the
// box store until a beat with in_last_box. Boxes beyond 64 are dropped and
// out_overflow is raised on every kept beat of that set. While loading, a
// box is taken every cycle. After the last box the channel stalls: each round
// scans the store for the best live box, one store read a cycle, then runs it
// against the live stored boxes of its class through the overlap pipeline,
// then places it in the output register. Kept boxes leave on the kept channel
// in score order, earlier arrival first on equal scores, the final one with
// out_last_kept. A stall on the kept channel holds the output register and
// delays the next round. Reset empties the set, clears the suppression marks
// and sets the overlap threshold to 29491; the store itself is not cleared.
// ----------------------------------------------------------------------------
module class_aware_box_suppression (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        box_valid,
	output logic                        box_stall,
	input  cabs_pkg::box_in_t           box,
	output logic                        kept_valid,
	input  logic                        kept_stall,
	output cabs_pkg::box_out_t          kept,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cabs_pkg::ADDR_W-1:0] paddr,
	input  logic [cabs_pkg::DATA_W-1:0] pwdata,
	output logic [cabs_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import cabs_pkg::*;

	cabs_state_t state_q, state_d;
	logic [CNT_W-1:0]     count_q, scan_q;
	logic                 ovf_q;
	logic [MAX_BOXES-1:0] ret_q, live_mask;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic                 best_vld_q;
	logic [IDX_W-1:0]     best_idx_q;
	entry_t               best_q, rd_data, wr_data;
	logic [THR_W-1:0]     thr_q;
	logic                 out_vld_q;
	box_out_t             out_q;

	logic box_take, store_ok, rd_en, scan_done, live_any;
	logic start_round, retire_best, end_set, load_out, last_kept;
	cabs_tag_t iou_req, iou_rsp;
	logic iou_hit, iou_busy;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_IOU_THR) ? DATA_W'(thr_q) : '0;

	assign box_stall = (state_q != ST_LOAD);
	assign box_take  = box_valid && !box_stall;
	assign store_ok  = (count_q < CNT_W'(MAX_BOXES));

	assign wr_data = {box.in_x1, box.in_y1, box.in_x2, box.in_y2, box.in_score, box.in_class};

	assign rd_en     = ((state_q == ST_FIND) || (state_q == ST_SUPP)) && (scan_q < count_q);
	assign scan_done = (scan_q == count_q) && !rd_vld_s1;

	always_comb begin
		for (int i = 0; i < MAX_BOXES; i++) begin
			live_mask[i] = !ret_q[i] && (CNT_W'(i) < count_q);
		end
	end
	assign live_any = |live_mask;

	assign iou_req = {(state_q == ST_SUPP) && rd_vld_s1 && !ret_q[rd_idx_s1]
		&& (rd_data.cls == best_q.cls), rd_idx_s1};

	cabs_box_mem u_mem (
		.clk     (clk),
		.wr_en   (box_take && store_ok),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (scan_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	cabs_iou u_iou (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (iou_req),
		.a      (best_q.corners),
		.b      (rd_data.corners),
		.thr    (thr_q),
		.rsp    (iou_rsp),
		.hit    (iou_hit),
		.busy   (iou_busy)
	);

	always_comb begin
		state_d     = state_q;
		start_round = 1'b0;
		retire_best = 1'b0;
		end_set     = 1'b0;
		load_out    = 1'b0;
		last_kept   = !live_any;
		unique case (state_q)
			ST_LOAD: begin
				if (box_take && box.in_last_box) begin
					state_d     = ST_FIND;
					start_round = 1'b1;
				end
			end
			ST_FIND: begin
				if (scan_done) begin
					if (best_vld_q) begin
						state_d     = ST_SUPP;
						retire_best = 1'b1;
					end else begin
						state_d = ST_LOAD;
						end_set = 1'b1;
					end
				end
			end
			ST_SUPP: begin
				if (scan_done && !iou_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_vld_q || !kept_stall) begin
					load_out = 1'b1;
					if (last_kept) begin
						state_d = ST_LOAD;
						end_set = 1'b1;
					end else begin
						state_d     = ST_FIND;
						start_round = 1'b1;
					end
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ovf_q      <= 1'b0;
			ret_q      <= '0;
			scan_q     <= '0;
			rd_vld_s1  <= 1'b0;
			best_vld_q <= 1'b0;
			thr_q      <= THR_RESET;
			out_vld_q  <= 1'b0;
		end else begin
			if (psel && penable && pwrite && (paddr == REG_IOU_THR)) begin
				thr_q <= pwdata[THR_W-1:0];
			end
			if (box_take) begin
				if (store_ok) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (state_q == ST_FIND && rd_vld_s1 && !ret_q[rd_idx_s1]
					&& (!best_vld_q || rd_data.score > best_q.score)) begin
				best_vld_q <= 1'b1;
			end
			if (retire_best) begin
				ret_q[best_idx_q] <= 1'b1;
				scan_q            <= '0;
			end
			if (iou_rsp.vld && iou_hit) begin
				ret_q[iou_rsp.idx] <= 1'b1;
			end
			if (start_round) begin
				scan_q     <= '0;
				best_vld_q <= 1'b0;
			end
			if (end_set) begin
				count_q    <= '0;
				ovf_q      <= 1'b0;
				ret_q      <= '0;
				scan_q     <= '0;
				best_vld_q <= 1'b0;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (!kept_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q[IDX_W-1:0];
		if (state_q == ST_FIND && rd_vld_s1 && !ret_q[rd_idx_s1]
				&& (!best_vld_q || rd_data.score > best_q.score)) begin
			best_q     <= rd_data;
			best_idx_q <= rd_idx_s1;
		end
		if (load_out) begin
			out_q.out_x1        <= best_q.corners.x1;
			out_q.out_y1        <= best_q.corners.y1;
			out_q.out_x2        <= best_q.corners.x2;
			out_q.out_y2        <= best_q.corners.y2;
			out_q.out_score     <= best_q.score;
			out_q.out_class     <= best_q.cls;
			out_q.out_last_kept <= last_kept;
			out_q.out_overflow  <= ovf_q;
		end
	end

	assign kept_valid = out_vld_q;
	assign kept       = out_q;

endmodule

// ===== dv/cabs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabs_checker
// predicts kept boxes from accepted box beats and compares kept beats
// ----------------------------------------------------------------------------
// Watches the box and kept channels and the register port. The first 64
// accepted beats of a set go into a local copy; on the last box it is run
// through greedy per-class suppression and the kept boxes are queued. Kept
// beats are compared field by field against the oldest queued box.
// ----------------------------------------------------------------------------
module cabs_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        box_valid,
	input  logic                        box_stall,
	input  cabs_pkg::box_in_t           box,
	input  logic                        kept_valid,
	input  logic                        kept_stall,
	input  cabs_pkg::box_out_t          kept,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cabs_pkg::ADDR_W-1:0] paddr,
	input  logic [cabs_pkg::DATA_W-1:0] pwdata,
	input  logic                        pready,
	output int                          fail_count,
	output int                          pending
);
	import cabs_pkg::*;

	box_in_t  set_boxes [MAX_BOXES];
	int       set_size;
	bit       set_dropped;
	logic [THR_W-1:0] threshold;
	box_out_t kept_q[$];

	function automatic longint extent(longint lo, longint hi);
		return hi > lo ? hi - lo : 0;
	endfunction

	function automatic bit overlaps(box_in_t a, box_in_t b);
		longint ix1, iy1, ix2, iy2, inter, ua;
		ix1 = a.in_x1 > b.in_x1 ? a.in_x1 : b.in_x1;
		iy1 = a.in_y1 > b.in_y1 ? a.in_y1 : b.in_y1;
		ix2 = a.in_x2 < b.in_x2 ? a.in_x2 : b.in_x2;
		iy2 = a.in_y2 < b.in_y2 ? a.in_y2 : b.in_y2;
		inter = extent(ix1, ix2) * extent(iy1, iy2);
		if (inter <= 0) return 0;
		ua = extent(a.in_x1, a.in_x2) * extent(a.in_y1, a.in_y2)
			+ extent(b.in_x1, b.in_x2) * extent(b.in_y1, b.in_y2) - inter;
		if (ua <= 0) return 0;
		return inter * 65536 > longint'(threshold) * ua;
	endfunction

	task automatic suppress_set();
		int order[MAX_BOXES];
		bit gone[MAX_BOXES];
		int keep[$];
		int i, j, v;
		box_out_t o;
		for (i = 0; i < set_size; i++) begin
			j = i;
			while (j > 0 && set_boxes[order[j-1]].in_score < set_boxes[i].in_score) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
			gone[i] = 0;
		end
		for (i = 0; i < set_size; i++) begin
			if (gone[i]) continue;
			keep = {keep, order[i]};
			for (j = i + 1; j < set_size; j++)
				if (!gone[j] && set_boxes[order[i]].in_class == set_boxes[order[j]].in_class
					&& overlaps(set_boxes[order[i]], set_boxes[order[j]]))
					gone[j] = 1;
		end
		foreach (keep[k]) begin
			v = keep[k];
			o.out_x1 = set_boxes[v].in_x1;
			o.out_y1 = set_boxes[v].in_y1;
			o.out_x2 = set_boxes[v].in_x2;
			o.out_y2 = set_boxes[v].in_y2;
			o.out_score = set_boxes[v].in_score;
			o.out_class = set_boxes[v].in_class;
			o.out_last_kept = (k == keep.size() - 1);
			o.out_overflow = set_dropped;
			kept_q = {kept_q, o};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size = 0;
			set_dropped = 0;
			threshold <= THR_RESET;
			fail_count <= 0;
			kept_q.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_IOU_THR)
				threshold <= pwdata[THR_W-1:0];
			if (box_valid && !box_stall) begin
				if (set_size < MAX_BOXES) begin
					set_boxes[set_size] = box;
					set_size = set_size + 1;
				end else begin
					set_dropped = 1;
				end
				if (box.in_last_box) begin
					suppress_set();
					set_size = 0;
					set_dropped = 0;
				end
			end
			if (kept_valid && !kept_stall) begin
				if (kept_q.size() == 0) begin
					$error("kept beat with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					box_out_t e;
					int bad;
					e = kept_q.pop_front();
					bad = 0;
					if (kept.out_x1 !== e.out_x1) begin
						$error("out_x1 exp %0d got %0d", e.out_x1, kept.out_x1); bad++;
					end
					if (kept.out_y1 !== e.out_y1) begin
						$error("out_y1 exp %0d got %0d", e.out_y1, kept.out_y1); bad++;
					end
					if (kept.out_x2 !== e.out_x2) begin
						$error("out_x2 exp %0d got %0d", e.out_x2, kept.out_x2); bad++;
					end
					if (kept.out_y2 !== e.out_y2) begin
						$error("out_y2 exp %0d got %0d", e.out_y2, kept.out_y2); bad++;
					end
					if (kept.out_score !== e.out_score) begin
						$error("out_score exp %0d got %0d", e.out_score, kept.out_score); bad++;
					end
					if (kept.out_class !== e.out_class) begin
						$error("out_class exp %0d got %0d", e.out_class, kept.out_class); bad++;
					end
					if (kept.out_last_kept !== e.out_last_kept) begin
						$error("out_last_kept exp %0d got %0d", e.out_last_kept,
							kept.out_last_kept); bad++;
					end
					if (kept.out_overflow !== e.out_overflow) begin
						$error("out_overflow exp %0d got %0d", e.out_overflow,
							kept.out_overflow); bad++;
					end
					fail_count <= fail_count + bad;
				end
			end
			pending <= kept_q.size();
		end
	end
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the per-class box suppression block
// ----------------------------------------------------------------------------
// Sends sets of boxes, mostly clustered two-class overlaps with random
// content, some full random and one overflowing set, under several idle and
// stall mixes and threshold settings. A checker beside the block predicts and
// compares the kept beats; this module only drives and decides.
// ----------------------------------------------------------------------------
module testbench;
	import cabs_pkg::*;

	logic clk, arst_n;
	logic box_valid, box_stall, kept_valid, kept_stall;
	box_in_t box;
	box_out_t kept;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;
	int fail_count, pending;
	int send_idle, recv_stall, hold_off;
	longint cycles;

	class_aware_box_suppression DUT (.*);
	cabs_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 3000000) begin
				$display("class_aware_box_suppression: mismatch");
				$finish;
			end
		end
	end

	// receiver stall, with a long hold-off when requested
	initial begin
		kept_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				kept_stall <= 1;
				hold_off--;
			end else begin
				kept_stall <= ($urandom_range(99) < recv_stall);
			end
		end
	end

	task automatic write_threshold(int unsigned v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_IOU_THR; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send_box(box_in_t b);
		while ($urandom_range(99) < send_idle) begin
			box_valid <= 0;
			@(posedge clk);
		end
		box_valid <= 1;
		box <= b;
		@(posedge clk);
		while (box_stall) @(posedge clk);
	endtask

	task automatic wait_idle();
		box_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic box_in_t make_box(bit clustered, logic [7:0] cls, bit last);
		box_in_t b;
		int x, y;
		if (clustered) begin
			x = $urandom_range(200) - 100;
			y = $urandom_range(200) - 100;
			b.in_x1 = 16'(x); b.in_y1 = 16'(y);
			b.in_x2 = 16'(x + 40 + $urandom_range(60));
			b.in_y2 = 16'(y + 40 + $urandom_range(60));
			b.in_class = cls;
			b.in_score = ($urandom_range(3) == 0) ? 16'd500 : 16'($urandom);
		end else begin
			b.in_x1 = 16'($urandom); b.in_y1 = 16'($urandom);
			b.in_x2 = 16'($urandom); b.in_y2 = 16'($urandom);
			b.in_score = 16'($urandom);
			b.in_class = 8'($urandom);
		end
		b.in_last_box = last;
		return b;
	endfunction

	task automatic send_set(int n, bit clustered);
		logic [7:0] c0;
		c0 = 8'($urandom);
		for (int i = 0; i < n; i++)
			send_box(make_box(clustered && $urandom_range(9) != 0,
				($urandom_range(1) ? c0 : c0 + 8'd1), i == n - 1));
	endtask

	initial begin
		box_in_t b;
		int total;
		arst_n = 0;
		box_valid = 0; box = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		send_idle = 0; recv_stall = 0; hold_off = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, identical boxes, inverted and empty boxes
		b = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'hffff, 8'hff, 1'b0};
		send_box(b);
		b = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'hffff, 8'hff, 1'b0};
		send_box(b);
		b = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'h0000, 8'h00, 1'b0};
		send_box(b);
		b = '{16'sd10, 16'sd10, 16'sd10, 16'sd50, 16'h0001, 8'h00, 1'b0};
		send_box(b);
		b = '{16'sd0, 16'sd0, 16'sd100, 16'sd100, 16'h8000, 8'h00, 1'b0};
		send_box(b);
		b = '{16'sd0, 16'sd0, 16'sd100, 16'sd100, 16'h8000, 8'h01, 1'b0};
		send_box(b);
		b = '{16'sd5, 16'sd0, 16'sd100, 16'sd100, 16'h8000, 8'h00, 1'b1};
		send_box(b);
		b = '{16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'h1234, 8'h55, 1'b1};
		send_box(b);
		wait_idle();
		write_threshold(65536);
		send_set(6, 1);
		wait_idle();
		write_threshold(0);
		send_set(6, 1);
		wait_idle();
		write_threshold(131071);
		send_set(4, 1);
		wait_idle();
		// overflow: 66 boxes, last one dropped too
		write_threshold(29491);
		send_set(66, 1);
		wait_idle();

		// random phases
		total = 0;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 58 : 23) : 0;
			recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 58 : 23) : 0;
			write_threshold(ph == 0 ? 16384 : $urandom_range(65536));
			if (ph == 2) hold_off = 300;
			for (int s = 0; s < 6; s++) begin
				int n;
				n = $urandom_range(1, 7);
				send_set(n, $urandom_range(3) != 0);
				total += n;
			end
			wait_idle();
		end

		wait_idle();
		if (fail_count == 0 && pending == 0)
			$display("class_aware_box_suppression: match");
		else
			$display("class_aware_box_suppression: mismatch");
		$finish;
	end
endmodule

// ===== files.f =====
hw/rtl/cabs_pkg.sv
hw/rtl/cabs_box_mem.sv
hw/rtl/cabs_iou.sv
hw/rtl/class_aware_box_suppression.sv
dv/cabs_checker.sv
dv/testbench.sv
